### src/rpa_pkg.sv
// Shared types, constants and helpers for the reference-counted page allocator.
// No dependencies; used by rpa_ctrl and refcount_page_allocator.
package rpa_pkg;

    // Geometry. PAGE_BYTES is taken to be a power of two.
    localparam int NUM_PAGES  = 512;
    localparam int PAGE_BYTES = 4096;

    localparam int PAGE_W   = $clog2(NUM_PAGES);
    localparam int OFFS_W   = $clog2(PAGE_BYTES);
    localparam int CNT_W    = 8;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // Occupancy bitmap: one bit per page, WORD_W pages per row.
    localparam int WORD_LOG = 5;
    localparam int WORD_W   = 1 << WORD_LOG;
    localparam int NUM_ROWS = (NUM_PAGES + WORD_W - 1) / WORD_W;
    localparam int ROW_W    = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;

    // Page-number compare width: holds any page number and the 9-bit registers.
    localparam int CMP_W    = 17;

    // Field widths.
    localparam int CFG_W    = 9;
    localparam int CFG_IDX_W = 1;
    localparam int OP_W     = 2;
    localparam int DATA_W   = 32;
    localparam int PADDR_W  = 21;
    localparam int ST_W     = 2;
    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 24;

    localparam logic [CFG_W-1:0] FIRST_USER_RST = 9'd256;
    localparam logic [CFG_W-1:0] CONSOLE_RST    = 9'd184;

    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_USER = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CONSOLE    = 1'd1;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC  = 2'd0,
        OP_FREE   = 2'd1,
        OP_ADDREF = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [ST_W-1:0] {
        STAT_DONE    = 2'd0,
        STAT_NOPAGE  = 2'd1,
        STAT_TOOBIG  = 2'd2,
        STAT_IGNORED = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_ALLOC_WR,
        S_OP_RD,
        S_OP_WR,
        S_RESP
    } t_state;

    typedef struct packed {
        logic              re;
        logic              we;
        logic [PAGE_W-1:0] addr;
        logic [CNT_W-1:0]  wdata;
    } t_cnt_port;

    typedef struct packed {
        logic              re;
        logic              we;
        logic [ROW_W-1:0]  addr;
        logic [WORD_W-1:0] wdata;
    } t_bmp_port;

    typedef struct packed {
        logic               valid;
        logic [PADDR_W-1:0] page_address;
        t_status            status;
    } t_result;

    // Page number may be handed out under the current register settings.
    function automatic logic f_allocatable(input logic [CMP_W-1:0] pg,
                                           input logic [CFG_W-1:0] first,
                                           input logic [CFG_W-1:0] console);
        return (pg >= CMP_W'(first)) && (pg != CMP_W'(console));
    endfunction

    function automatic logic [ROW_W-1:0] f_row(input logic [CMP_W-1:0] pg);
        logic [CMP_W-1:0] s;
        s = pg >> WORD_LOG;
        return s[ROW_W-1:0];
    endfunction

    function automatic logic [WORD_LOG-1:0] f_bit(input logic [CMP_W-1:0] pg);
        return pg[WORD_LOG-1:0];
    endfunction

endpackage

### src/rpa_ram.sv
// Generic single-port synchronous RAM with registered read.
// No dependencies.
module rpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic             i_re,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/rpa_ctrl.sv
// Request sequencer: decode, bitmap scan, count read-modify-write, clear pass.
// Depends on rpa_pkg; drives the count RAM and bitmap RAM in the top level.
module rpa_ctrl (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_req_valid,
    output logic                             o_req_ready,
    input  logic [rpa_pkg::IN_TDATA_W-1:0]   i_req_data,
    input  logic [rpa_pkg::OP_W-1:0]         i_req_op,
    input  logic [rpa_pkg::CFG_W-1:0]        i_first_user,
    input  logic [rpa_pkg::CFG_W-1:0]        i_console,
    output rpa_pkg::t_result                 o_res,
    input  logic                             i_res_ready,
    output rpa_pkg::t_cnt_port               o_cnt,
    input  logic [rpa_pkg::CNT_W-1:0]        i_cnt_rdata,
    output rpa_pkg::t_bmp_port               o_bmp,
    input  logic [rpa_pkg::WORD_W-1:0]       i_bmp_rdata
);

    localparam int CW = rpa_pkg::CMP_W;

    rpa_pkg::t_state  r_state, n_state;
    rpa_pkg::t_op     r_op, n_op;
    rpa_pkg::t_status r_status, n_status;
    logic [rpa_pkg::PADDR_W-1:0] r_paddr, n_paddr;
    logic [rpa_pkg::PAGE_W-1:0]  r_page, n_page;
    logic [rpa_pkg::ROW_W-1:0]   r_row, n_row;
    logic [rpa_pkg::WORD_W-1:0]  r_row_data, n_row_data;
    logic [rpa_pkg::PAGE_W-1:0]  r_clr, n_clr;

    // request decode
    logic [rpa_pkg::DATA_W-1:0] req_bytes, req_addr, addr_page;
    logic                       addr_ok, too_big;
    logic [rpa_pkg::PAGE_W-1:0] req_page;
    rpa_pkg::t_op               req_op;

    // scan
    logic [rpa_pkg::WORD_W-1:0]   scan_mask;
    logic                         scan_hit;
    logic [rpa_pkg::WORD_LOG-1:0] scan_idx;
    logic [CW-1:0]                scan_page;
    logic [CW-1:0]                row_base;
    logic [63:0]                  paddr_wide;

    // count update
    logic [rpa_pkg::WORD_W-1:0] page_bit;
    logic [rpa_pkg::CNT_W-1:0]  cnt_dec, cnt_inc;

    always_comb begin
        req_op    = rpa_pkg::t_op'(i_req_op);
        req_bytes = i_req_data[31:0];
        req_addr  = i_req_data[63:32];
        addr_page = req_addr >> rpa_pkg::OFFS_W;
        req_page  = addr_page[rpa_pkg::PAGE_W-1:0];
        addr_ok   = (req_addr[rpa_pkg::OFFS_W-1:0] == '0)
                 && ({1'b0, addr_page} < 33'(rpa_pkg::NUM_PAGES));
        too_big   = {1'b0, req_bytes} > 33'(rpa_pkg::PAGE_BYTES);
    end

    // allocatable, nonzero-count-free pages of the row just read
    always_comb begin
        logic [CW-1:0] pg;
        row_base = CW'(r_row) << rpa_pkg::WORD_LOG;
        for (int b = 0; b < rpa_pkg::WORD_W; b++) begin
            pg = row_base | CW'(b);
            scan_mask[b] = !i_bmp_rdata[b] && (pg < CW'(rpa_pkg::NUM_PAGES))
                        && rpa_pkg::f_allocatable(pg, i_first_user, i_console);
        end
        scan_hit = 1'b0;
        scan_idx = '0;
        for (int b = rpa_pkg::WORD_W - 1; b >= 0; b--) begin
            if (scan_mask[b]) begin
                scan_hit = 1'b1;
                scan_idx = rpa_pkg::WORD_LOG'(b);
            end
        end
        scan_page = row_base | CW'(scan_idx);
    end

    always_comb begin
        page_bit   = rpa_pkg::WORD_W'(1) << rpa_pkg::f_bit(CW'(r_page));
        cnt_dec    = i_cnt_rdata - rpa_pkg::CNT_W'(1);
        cnt_inc    = (i_cnt_rdata == rpa_pkg::CNT_MAX) ? i_cnt_rdata
                                                       : i_cnt_rdata + rpa_pkg::CNT_W'(1);
        paddr_wide = 64'(r_page) << rpa_pkg::OFFS_W;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rpa_pkg::S_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_status   <= n_status;
        r_paddr    <= n_paddr;
        r_page     <= n_page;
        r_row      <= n_row;
        r_row_data <= n_row_data;
    end

    always_comb begin
        n_state    = r_state;
        n_clr      = r_clr;
        n_op       = r_op;
        n_status   = r_status;
        n_paddr    = r_paddr;
        n_page     = r_page;
        n_row      = r_row;
        n_row_data = r_row_data;
        o_req_ready = 1'b0;
        o_cnt       = '0;
        o_bmp       = '0;
        o_res.valid        = 1'b0;
        o_res.page_address = r_paddr;
        o_res.status       = r_status;

        unique case (r_state)
            rpa_pkg::S_CLEAR: begin
                o_cnt.we   = 1'b1;
                o_cnt.addr = r_clr;
                o_bmp.we   = 1'b1;
                o_bmp.addr = rpa_pkg::f_row(CW'(r_clr));
                n_clr      = r_clr + rpa_pkg::PAGE_W'(1);
                if (r_clr == rpa_pkg::PAGE_W'(rpa_pkg::NUM_PAGES - 1)) begin
                    n_state = rpa_pkg::S_IDLE;
                end
            end
            rpa_pkg::S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    n_op     = req_op;
                    n_page   = req_page;
                    n_row    = rpa_pkg::f_row(CW'(req_page));
                    n_paddr  = '0;
                    n_status = rpa_pkg::STAT_IGNORED;
                    unique case (req_op)
                        rpa_pkg::OP_ALLOC: begin
                            if (too_big) begin
                                n_status = rpa_pkg::STAT_TOOBIG;
                                n_state  = rpa_pkg::S_RESP;
                            end else if (CW'(i_first_user) >= CW'(rpa_pkg::NUM_PAGES)) begin
                                n_status = rpa_pkg::STAT_NOPAGE;
                                n_state  = rpa_pkg::S_RESP;
                            end else begin
                                n_row   = rpa_pkg::f_row(CW'(i_first_user));
                                n_state = rpa_pkg::S_SCAN_RD;
                            end
                        end
                        rpa_pkg::OP_FREE: begin
                            // address zero is never freed
                            if (addr_ok && (req_addr != '0)
                                && rpa_pkg::f_allocatable(CW'(req_page), i_first_user,
                                                          i_console)) begin
                                n_state = rpa_pkg::S_OP_RD;
                            end else begin
                                n_state = rpa_pkg::S_RESP;
                            end
                        end
                        rpa_pkg::OP_ADDREF: begin
                            n_state = addr_ok ? rpa_pkg::S_OP_RD : rpa_pkg::S_RESP;
                        end
                        rpa_pkg::OP_NONE: begin
                            n_state = rpa_pkg::S_RESP;
                        end
                    endcase
                end
            end
            rpa_pkg::S_SCAN_RD: begin
                o_bmp.re   = 1'b1;
                o_bmp.addr = r_row;
                n_state    = rpa_pkg::S_SCAN_CHK;
            end
            rpa_pkg::S_SCAN_CHK: begin
                if (scan_hit) begin
                    n_page     = scan_page[rpa_pkg::PAGE_W-1:0];
                    n_row_data = i_bmp_rdata | (rpa_pkg::WORD_W'(1) << scan_idx);
                    n_state    = rpa_pkg::S_ALLOC_WR;
                end else if (r_row == rpa_pkg::ROW_W'(rpa_pkg::NUM_ROWS - 1)) begin
                    n_status = rpa_pkg::STAT_NOPAGE;
                    n_state  = rpa_pkg::S_RESP;
                end else begin
                    n_row   = r_row + rpa_pkg::ROW_W'(1);
                    n_state = rpa_pkg::S_SCAN_RD;
                end
            end
            rpa_pkg::S_ALLOC_WR: begin
                o_cnt.we    = 1'b1;
                o_cnt.addr  = r_page;
                o_cnt.wdata = rpa_pkg::CNT_W'(1);
                o_bmp.we    = 1'b1;
                o_bmp.addr  = r_row;
                o_bmp.wdata = r_row_data;
                n_paddr     = paddr_wide[rpa_pkg::PADDR_W-1:0];
                n_status    = rpa_pkg::STAT_DONE;
                n_state     = rpa_pkg::S_RESP;
            end
            rpa_pkg::S_OP_RD: begin
                o_cnt.re   = 1'b1;
                o_cnt.addr = r_page;
                o_bmp.re   = 1'b1;
                o_bmp.addr = r_row;
                n_state    = rpa_pkg::S_OP_WR;
            end
            rpa_pkg::S_OP_WR: begin
                o_cnt.addr = r_page;
                o_bmp.addr = r_row;
                if (r_op == rpa_pkg::OP_FREE) begin
                    if (i_cnt_rdata != '0) begin
                        o_cnt.we    = 1'b1;
                        o_cnt.wdata = cnt_dec;
                        o_bmp.we    = 1'b1;
                        o_bmp.wdata = (cnt_dec == '0) ? (i_bmp_rdata & ~page_bit)
                                                      : i_bmp_rdata;
                        n_status    = rpa_pkg::STAT_DONE;
                    end
                end else begin
                    o_cnt.we    = 1'b1;
                    o_cnt.wdata = cnt_inc;
                    o_bmp.we    = 1'b1;
                    o_bmp.wdata = i_bmp_rdata | page_bit;
                    n_status    = rpa_pkg::STAT_DONE;
                end
                n_state = rpa_pkg::S_RESP;
            end
            rpa_pkg::S_RESP: begin
                o_res.valid = 1'b1;
                if (i_res_ready) begin
                    n_state = rpa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rpa_pkg::S_IDLE;
            end
        endcase
    end

endmodule

### src/refcount_page_allocator.sv
// Top level of the reference-counted physical page allocator.
// Depends on rpa_pkg, rpa_ram and rpa_ctrl.
//
// Keeps an 8-bit reference count for each of NUM_PAGES pages in a count RAM,
// plus a one-bit-per-page occupancy bitmap RAM (32 pages per row) that is set
// exactly when the page's count is nonzero. One request is in work at a time;
// the result lands in an output register, so the next request is taken while
// a result still waits. From input accept to result loaded, free and
// add-reference read both RAMs, write both back and respond; rejected
// requests go straight to respond; allocate reads and checks bitmap rows
// in turn, starting at the row of first_user_page and ending at the first
// row with a usable page or at the last row, then writes both RAMs and
// responds. The next request is accepted from idle only after the result
// is loaded, so a new request is not taken before the last one is through.
// The scan is set by the single bitmap RAM port, one row read and one row
// checked in turn. After reset a clearing pass zeroes both RAMs, one page
// per cycle, over all NUM_PAGES pages (512 at the default); input tready
// stays low during it, configuration writes are taken throughout.
// Registers: index 0 first_user_page, index 1 console_page; write them only
// while idle. PAGE_BYTES must be a power of two.
module refcount_page_allocator (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration write
    input  logic                               i_cfg_we,
    input  logic [rpa_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [rpa_pkg::CFG_W-1:0]          i_cfg_data,
    // request stream
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  logic [rpa_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,  // [31:0] request_bytes,
                                                                // [63:32] phys_address
    input  logic [rpa_pkg::OP_W-1:0]           i_s_axis_tuser,  // [1:0] operation
    // result stream
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    output logic [rpa_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,  // [20:0] page_address,
                                                                // [23:21] zero
    output logic [rpa_pkg::ST_W-1:0]           o_m_axis_tuser   // [1:0] status
);

    logic [rpa_pkg::CFG_W-1:0] r_first_user;
    logic [rpa_pkg::CFG_W-1:0] r_console;

    logic                         r_out_valid;
    logic [rpa_pkg::PADDR_W-1:0]  r_out_paddr;
    rpa_pkg::t_status             r_out_status;

    rpa_pkg::t_result   res;
    logic               res_ready;
    rpa_pkg::t_cnt_port cnt_port;
    rpa_pkg::t_bmp_port bmp_port;
    logic [rpa_pkg::CNT_W-1:0]  cnt_rdata;
    logic [rpa_pkg::WORD_W-1:0] bmp_rdata;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_user <= rpa_pkg::FIRST_USER_RST;
            r_console    <= rpa_pkg::CONSOLE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                rpa_pkg::CFG_FIRST_USER: r_first_user <= i_cfg_data;
                rpa_pkg::CFG_CONSOLE:    r_console    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // output register: loads when empty or being drained
    assign res_ready = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res.valid) begin
            r_out_paddr  <= res.page_address;
            r_out_status <= res.status;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = rpa_pkg::OUT_TDATA_W'(r_out_paddr);
    assign o_m_axis_tuser  = r_out_status;

    rpa_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_s_axis_tvalid),
        .o_req_ready  (o_s_axis_tready),
        .i_req_data   (i_s_axis_tdata),
        .i_req_op     (i_s_axis_tuser),
        .i_first_user (r_first_user),
        .i_console    (r_console),
        .o_res        (res),
        .i_res_ready  (res_ready),
        .o_cnt        (cnt_port),
        .i_cnt_rdata  (cnt_rdata),
        .o_bmp        (bmp_port),
        .i_bmp_rdata  (bmp_rdata)
    );

    // per-page reference counts
    rpa_ram #(
        .WIDTH (rpa_pkg::CNT_W),
        .DEPTH (rpa_pkg::NUM_PAGES),
        .AW    (rpa_pkg::PAGE_W)
    ) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_port.we),
        .i_re    (cnt_port.re),
        .i_addr  (cnt_port.addr),
        .i_wdata (cnt_port.wdata),
        .o_rdata (cnt_rdata)
    );

    // occupancy bitmap, bit set while count is nonzero
    rpa_ram #(
        .WIDTH (rpa_pkg::WORD_W),
        .DEPTH (rpa_pkg::NUM_ROWS),
        .AW    (rpa_pkg::ROW_W)
    ) u_bmp_ram (
        .i_clk   (i_clk),
        .i_we    (bmp_port.we),
        .i_re    (bmp_port.re),
        .i_addr  (bmp_port.addr),
        .i_wdata (bmp_port.wdata),
        .o_rdata (bmp_rdata)
    );

endmodule
